// ===== hdl/cfpd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfpd_pkg
// Shared types, constants and tables of the circular fisheye point pipeline.
// ----------------------------------------------------------------------------
package cfpd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WBITS     = 30;
    localparam int EXP_TERMS = 10;
    localparam int EXP_TAB_N = 21;
    localparam int CFG_W     = 31;
    localparam int ZOOM_W    = 20;

    localparam logic [30:0] WONE = 31'(64'(1) << WBITS);

    typedef enum logic [1:0] {
        CFG_LENS_RADIUS = 2'd0,
        CFG_GAIN_K0     = 2'd1,
        CFG_FALLOFF_K1  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] focus_x;
        logic signed [31:0] focus_y;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic [ZOOM_W-1:0]  zoom;
        logic               in_range;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] focus_x;
        logic signed [31:0] focus_y;
        logic               neg_x;
        logic               neg_y;
        logic [30:0]        abs_x;
        logic [30:0]        abs_y;
        logic               at_focus;
        logic               in_lens;
        logic               in_range;
        logic [30:0]        dmag;
    } side_t;

    function automatic logic [30:0] exp_tab(input logic [4:0] idx);
        logic [30:0] v;
        case (idx)
            5'd0:    v = 31'd1073741824;
            5'd1:    v = 31'd395007542;
            5'd2:    v = 31'd145315153;
            5'd3:    v = 31'd53458458;
            5'd4:    v = 31'd19666265;
            5'd5:    v = 31'd7234816;
            5'd6:    v = 31'd2661540;
            5'd7:    v = 31'd979126;
            5'd8:    v = 31'd360200;
            5'd9:    v = 31'd132510;
            5'd10:   v = 31'd48748;
            5'd11:   v = 31'd17933;
            5'd12:   v = 31'd6597;
            5'd13:   v = 31'd2427;
            5'd14:   v = 31'd893;
            5'd15:   v = 31'd328;
            5'd16:   v = 31'd121;
            5'd17:   v = 31'd44;
            5'd18:   v = 31'd16;
            5'd19:   v = 31'd6;
            5'd20:   v = 31'd2;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

    // floor(2^32 / i), one below where that would not fit
    function automatic logic [31:0] recip(input int i);
        logic [31:0] v;
        case (i)
            1:       v = 32'd4294967295;
            2:       v = 32'd2147483648;
            3:       v = 32'd1431655765;
            4:       v = 32'd1073741824;
            5:       v = 32'd858993459;
            6:       v = 32'd715827882;
            7:       v = 32'd613566756;
            8:       v = 32'd536870912;
            9:       v = 32'd477218588;
            default: v = 32'd429496729;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/cfpd_isqrt.sv =====
// ----------------------------------------------------------------------------
// cfpd_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module cfpd_isqrt (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  cfpd_pkg::side_t      in_side,
    input  logic [61:0]          in_val,
    output logic                 out_valid,
    output cfpd_pkg::side_t      out_side
);

    localparam int NS = 31;

    logic [61:0]     v_reg   [NS];
    logic [61:0]     res_reg [NS];
    cfpd_pkg::side_t side_reg[NS];
    logic [NS-1:0]   valid_reg;

    for (genvar j = 0; j < NS; j++) begin : g_stage
        localparam logic [62:0] BIT = 63'(1) << (2 * (NS - 1 - j));
        logic [61:0]     v_in;
        logic [61:0]     res_in;
        cfpd_pkg::side_t side_in;
        logic            valid_in;
        logic [62:0]     trial;
        logic [61:0]     v_next;
        logic [61:0]     res_next;

        if (j == 0) begin : g_first
            assign v_in     = in_val;
            assign res_in   = '0;
            assign side_in  = in_side;
            assign valid_in = in_valid;
        end else begin : g_rest
            assign v_in     = v_reg[j-1];
            assign res_in   = res_reg[j-1];
            assign side_in  = side_reg[j-1];
            assign valid_in = valid_reg[j-1];
        end

        always_comb begin
            trial = {1'b0, res_in} + BIT;
            if ({1'b0, v_in} >= trial) begin
                v_next   = v_in - trial[61:0];
                res_next = (res_in >> 1) + BIT[61:0];
            end else begin
                v_next   = v_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                v_reg[j]    <= v_next;
                res_reg[j]  <= res_next;
                side_reg[j] <= side_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (en) begin
                valid_reg[j] <= valid_in;
            end
        end
    end

    always_comb begin
        out_side      = side_reg[NS-1];
        out_side.dmag = res_reg[NS-1][30:0];
    end

    assign out_valid = valid_reg[NS-1];

endmodule

// ===== hdl/cfpd_expneg.sv =====
// ----------------------------------------------------------------------------
// cfpd_expneg
// exp(-dist*k1) in Q1.30: table for the integer part, Horner series for the
// fraction, each term a multiply, a reciprocal multiply and a correction.
// ----------------------------------------------------------------------------
module cfpd_expneg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic [30:0]          falloff_k1,
    input  logic                 in_valid,
    input  cfpd_pkg::side_t      in_side,
    output logic                 out_valid,
    output cfpd_pkg::side_t      out_side,
    output logic [30:0]          out_e
);

    localparam int FB  = cfpd_pkg::FRAC_BITS;
    localparam int NT  = cfpd_pkg::EXP_TERMS;
    localparam int NS  = 3 * NT + 2;

    typedef struct packed {
        cfpd_pkg::side_t side;
        logic [29:0]     frac;
        logic [4:0]      idx;
        logic            big;
    } ectx_t;

    logic [61:0]     t_prod_reg;
    cfpd_pkg::side_t t_side_reg;
    logic            t_valid_reg;

    ectx_t           ctx_reg  [NS];
    logic [NS-1:0]   valid_reg;

    logic [29:0]     p_reg    [NT];
    logic [29:0]     pk_reg   [NT];
    logic [29:0]     q0_reg   [NT];
    logic [30:0]     r_reg    [NT];
    logic [61:0]     fin_reg;

    logic [61:0]     n_full;
    ectx_t           split_next;

    always_ff @(posedge aclk) begin
        if (en) begin
            t_prod_reg <= 62'(in_side.dmag) * 62'(falloff_k1);
            t_side_reg <= in_side;
        end
    end

    always_comb begin
        n_full          = t_prod_reg >> (2 * FB);
        split_next.side = t_side_reg;
        split_next.frac = 30'(t_prod_reg[2*FB-1:FB]) << (cfpd_pkg::WBITS - FB);
        split_next.idx  = n_full[4:0];
        split_next.big  = n_full >= 62'(cfpd_pkg::EXP_TAB_N);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_valid_reg  <= 1'b0;
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            t_valid_reg  <= in_valid;
            valid_reg[0] <= t_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_reg[0] <= split_next;
        end
    end

    for (genvar s = 1; s < NS; s++) begin : g_ctx
        always_ff @(posedge aclk) begin
            if (en) begin
                ctx_reg[s] <= ctx_reg[s-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (en) begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    for (genvar h = 0; h < NT; h++) begin : g_term
        localparam int          DIV_I = NT - h;
        localparam logic [31:0] RCP   = cfpd_pkg::recip(DIV_I);
        localparam int          SA    = 3 * h;
        logic [30:0] r_in;
        logic [60:0] fr_prod;
        logic [61:0] mq_prod;
        logic [33:0] rem;
        logic [29:0] q_fix;
        logic [30:0] r_next;

        if (h == 0) begin : g_first
            assign r_in = cfpd_pkg::WONE;
        end else begin : g_rest
            assign r_in = r_reg[h-1];
        end

        always_comb begin
            fr_prod = 61'(ctx_reg[SA].frac) * 61'(r_in);
            mq_prod = 62'(p_reg[h]) * 62'(RCP);
            rem     = 34'(pk_reg[h]) - 34'(q0_reg[h]) * 34'(DIV_I);
            q_fix   = q0_reg[h] + 30'(rem >= 34'(DIV_I));
            r_next  = cfpd_pkg::WONE - 31'(q_fix);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                p_reg[h]  <= fr_prod[59:30];
                q0_reg[h] <= mq_prod[61:32];
                pk_reg[h] <= p_reg[h];
                r_reg[h]  <= r_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (ctx_reg[NS-2].big) begin
                fin_reg <= '0;
            end else begin
                fin_reg <= 62'(cfpd_pkg::exp_tab(ctx_reg[NS-2].idx)) * 62'(r_reg[NT-1]);
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_side  = ctx_reg[NS-1].side;
    assign out_e     = fin_reg[60:30];

endmodule

// ===== hdl/cfpd_div.sv =====
// ----------------------------------------------------------------------------
// cfpd_div
// Pipelined restoring divider, 61-bit dividend by the 31-bit distance.
// ----------------------------------------------------------------------------
module cfpd_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  cfpd_pkg::side_t      in_side,
    input  logic [60:0]          in_num,
    output logic                 out_valid,
    output cfpd_pkg::side_t      out_side,
    output logic [60:0]          out_quo
);

    localparam int NS = 61;

    logic [60:0]     num_reg [NS];
    logic [60:0]     quo_reg [NS];
    logic [30:0]     rem_reg [NS];
    cfpd_pkg::side_t side_reg[NS];
    logic [NS-1:0]   valid_reg;

    for (genvar j = 0; j < NS; j++) begin : g_stage
        logic [60:0]     num_in;
        logic [60:0]     quo_in;
        logic [30:0]     rem_in;
        cfpd_pkg::side_t side_in;
        logic            valid_in;
        logic [31:0]     shifted;
        logic            take;
        logic [31:0]     diff;
        logic [30:0]     rem_next;
        logic [60:0]     quo_next;

        if (j == 0) begin : g_first
            assign num_in   = in_num;
            assign quo_in   = '0;
            assign rem_in   = '0;
            assign side_in  = in_side;
            assign valid_in = in_valid;
        end else begin : g_rest
            assign num_in   = num_reg[j-1];
            assign quo_in   = quo_reg[j-1];
            assign rem_in   = rem_reg[j-1];
            assign side_in  = side_reg[j-1];
            assign valid_in = valid_reg[j-1];
        end

        always_comb begin
            shifted  = {rem_in, num_in[NS-1-j]};
            take     = shifted >= {1'b0, side_in.dmag};
            diff     = shifted - {1'b0, side_in.dmag};
            rem_next = take ? diff[30:0] : shifted[30:0];
            quo_next = {quo_in[59:0], take};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[j]  <= num_in;
                quo_reg[j]  <= quo_next;
                rem_reg[j]  <= rem_next;
                side_reg[j] <= side_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (en) begin
                valid_reg[j] <= valid_in;
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_side  = side_reg[NS-1];
    assign out_quo   = quo_reg[NS-1];

endmodule

// ===== hdl/circular_fisheye_point_distort.sv =====
// ----------------------------------------------------------------------------
// circular_fisheye_point_distort
// Circular fisheye lens on one point per item, Q16.16 fixed point.
//
//   port group   dir  handshake       payload
//   s_*          in   s_valid/s_ready cfpd_pkg::in_item_t
//   m_*          out  m_valid/m_ready cfpd_pkg::out_item_t
//   cfg_*        in   cfg_wr_en       cfg_index, cfg_wdata
//
// One item per cycle unless the output stalls (5 front stages, 31 root
// stages, 33 exp stages, 1 product stage, 61 divider stages, 4 back stages).
// The whole pipeline advances when the output register is empty or taken.
// A one-entry skid buffer at the input keeps s_ready a register.
// Reset (aresetn, synchronous) clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module circular_fisheye_point_distort (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  cfpd_pkg::in_item_t      s_item,
    output logic                    m_valid,
    input  logic                    m_ready,
    output cfpd_pkg::out_item_t     m_item,
    input  logic                    cfg_wr_en,
    input  logic [1:0]              cfg_index,
    input  logic [30:0]             cfg_wdata
);

    localparam int FB = cfpd_pkg::FRAC_BITS;
    localparam logic [cfpd_pkg::ZOOM_W-1:0] ZOOM_ONE =
        cfpd_pkg::ZOOM_W'(64'(1) << FB);
    localparam logic [cfpd_pkg::ZOOM_W-1:0] ZOOM_TEN =
        cfpd_pkg::ZOOM_W'(64'(10) << FB);
    localparam logic [61:0] ZMAX = 62'(10) << FB;

    logic [30:0] lens_radius_reg;
    logic [30:0] gain_k0_reg;
    logic [30:0] falloff_k1_reg;

    logic                en;
    logic                skid_full_reg;
    cfpd_pkg::in_item_t  skid_reg;
    cfpd_pkg::in_item_t  in_item;
    logic                in_valid;

    logic                st1_valid_reg;
    cfpd_pkg::in_item_t  st1_item_reg;
    logic signed [32:0]  st1_dx_reg, st1_dy_reg;

    logic                st2_valid_reg;
    cfpd_pkg::in_item_t  st2_item_reg;
    logic [31:0]         st2_ax_reg, st2_ay_reg;
    logic                st2_nx_reg, st2_ny_reg;

    logic                st3_valid_reg;
    cfpd_pkg::in_item_t  st3_item_reg;
    logic [31:0]         st3_ax_reg, st3_ay_reg;
    logic                st3_nx_reg, st3_ny_reg;
    logic [63:0]         st3_sxx_reg, st3_syy_reg;
    logic [61:0]         st3_r2_reg;

    logic                st4_valid_reg;
    cfpd_pkg::in_item_t  st4_item_reg;
    logic [31:0]         st4_ax_reg, st4_ay_reg;
    logic                st4_nx_reg, st4_ny_reg;
    logic [64:0]         st4_sum_reg;
    logic [61:0]         st4_r2_reg;
    logic [63:0]         st4_r3_reg;

    logic                st5_valid_reg;
    cfpd_pkg::side_t     st5_side_reg;
    logic [61:0]         st5_val_reg;
    cfpd_pkg::side_t     st5_side_next;

    logic                sq_valid, ex_valid, dv_valid;
    cfpd_pkg::side_t     sq_side, ex_side, dv_side;
    logic [30:0]         ex_e;
    logic [60:0]         dv_quo;

    logic                st6_valid_reg;
    cfpd_pkg::side_t     st6_side_reg;
    logic [61:0]         st6_num_reg;

    logic                st7_valid_reg;
    cfpd_pkg::side_t     st7_side_reg;
    logic [61:0]         st7_k_reg;

    logic                st8_valid_reg;
    cfpd_pkg::side_t     st8_side_reg;
    logic [cfpd_pkg::ZOOM_W-1:0] st8_zoom_reg;
    logic [61:0]         st8_xl_reg, st8_xh_reg, st8_yl_reg, st8_yh_reg;
    logic [61:0]         zk;
    logic [61:0]         zsel;

    logic                st9_valid_reg;
    cfpd_pkg::side_t     st9_side_reg;
    logic [cfpd_pkg::ZOOM_W-1:0] st9_zoom_reg;
    logic [33:0]         st9_mx_reg, st9_my_reg;
    logic [63:0]         sum_x, sum_y;

    logic                m_valid_reg;
    cfpd_pkg::out_item_t m_item_reg;
    cfpd_pkg::out_item_t m_item_next;
    logic signed [35:0]  mov_x, mov_y;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sh07FFFFFFF) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -36'sh080000000) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lens_radius_reg <= 31'd6553600;
            gain_k0_reg     <= 31'd65536;
            falloff_k1_reg  <= 31'd65536;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                cfpd_pkg::CFG_LENS_RADIUS: lens_radius_reg <= cfg_wdata;
                cfpd_pkg::CFG_GAIN_K0:     gain_k0_reg     <= cfg_wdata;
                cfpd_pkg::CFG_FALLOFF_K1:  falloff_k1_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign en       = m_ready || !m_valid_reg;
    assign s_ready  = !skid_full_reg;
    assign in_item  = skid_full_reg ? skid_reg : s_item;
    assign in_valid = skid_full_reg || s_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_full_reg <= 1'b0;
        end else if (en) begin
            skid_full_reg <= 1'b0;
        end else if (s_valid && !skid_full_reg) begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!en && s_valid && !skid_full_reg) begin
            skid_reg <= s_item;
        end
    end

    // front stages: difference, magnitude, squares, sum, compares
    always_ff @(posedge aclk) begin
        if (en) begin
            st1_item_reg <= in_item;
            st1_dx_reg   <= 33'(in_item.point_x) - 33'(in_item.focus_x);
            st1_dy_reg   <= 33'(in_item.point_y) - 33'(in_item.focus_y);

            st2_item_reg <= st1_item_reg;
            st2_nx_reg   <= st1_dx_reg[32];
            st2_ny_reg   <= st1_dy_reg[32];
            st2_ax_reg   <= st1_dx_reg[32] ? 32'(-st1_dx_reg) : st1_dx_reg[31:0];
            st2_ay_reg   <= st1_dy_reg[32] ? 32'(-st1_dy_reg) : st1_dy_reg[31:0];

            st3_item_reg <= st2_item_reg;
            st3_nx_reg   <= st2_nx_reg;
            st3_ny_reg   <= st2_ny_reg;
            st3_ax_reg   <= st2_ax_reg;
            st3_ay_reg   <= st2_ay_reg;
            st3_sxx_reg  <= 64'(st2_ax_reg) * 64'(st2_ax_reg);
            st3_syy_reg  <= 64'(st2_ay_reg) * 64'(st2_ay_reg);
            st3_r2_reg   <= 62'(lens_radius_reg) * 62'(lens_radius_reg);

            st4_item_reg <= st3_item_reg;
            st4_nx_reg   <= st3_nx_reg;
            st4_ny_reg   <= st3_ny_reg;
            st4_ax_reg   <= st3_ax_reg;
            st4_ay_reg   <= st3_ay_reg;
            st4_sum_reg  <= 65'(st3_sxx_reg) + 65'(st3_syy_reg);
            st4_r2_reg   <= st3_r2_reg;
            st4_r3_reg   <= 64'(st3_r2_reg) + (64'(st3_r2_reg) << 1);

            st5_side_reg <= st5_side_next;
            st5_val_reg  <= st4_sum_reg[61:0];
        end
    end

    always_comb begin
        st5_side_next.point_x  = st4_item_reg.point_x;
        st5_side_next.point_y  = st4_item_reg.point_y;
        st5_side_next.focus_x  = st4_item_reg.focus_x;
        st5_side_next.focus_y  = st4_item_reg.focus_y;
        st5_side_next.neg_x    = st4_nx_reg;
        st5_side_next.neg_y    = st4_ny_reg;
        st5_side_next.abs_x    = st4_ax_reg[30:0];
        st5_side_next.abs_y    = st4_ay_reg[30:0];
        st5_side_next.at_focus = st4_sum_reg == '0;
        st5_side_next.in_lens  = (st4_sum_reg != '0) && (st4_sum_reg < 65'(st4_r2_reg));
        st5_side_next.in_range = st4_sum_reg < 65'(st4_r3_reg);
        st5_side_next.dmag     = '0;
    end

    cfpd_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (st5_valid_reg),
        .in_side   (st5_side_reg),
        .in_val    (st5_val_reg),
        .out_valid (sq_valid),
        .out_side  (sq_side)
    );

    cfpd_expneg u_expneg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .falloff_k1 (falloff_k1_reg),
        .in_valid   (sq_valid),
        .in_side    (sq_side),
        .out_valid  (ex_valid),
        .out_side   (ex_side),
        .out_e      (ex_e)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            st6_side_reg <= ex_side;
            st6_num_reg  <= 62'(gain_k0_reg) * 62'(cfpd_pkg::WONE - ex_e);
        end
    end

    cfpd_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (st6_valid_reg),
        .in_side   (st6_side_reg),
        .in_num    (st6_num_reg[60:0]),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_quo   (dv_quo)
    );

    // back stages: scale, zoom, move, saturate
    always_comb begin
        zk    = st7_k_reg >> (cfpd_pkg::WBITS - FB);
        zsel  = (zk < ZMAX) ? zk : ZMAX;
        sum_x = 64'(st8_xl_reg) + (64'(st8_xh_reg) << 31);
        sum_y = 64'(st8_yl_reg) + (64'(st8_yh_reg) << 31);
        mov_x = st9_side_reg.neg_x ? 36'(st9_side_reg.focus_x) - 36'(st9_mx_reg)
                                   : 36'(st9_side_reg.focus_x) + 36'(st9_mx_reg);
        mov_y = st9_side_reg.neg_y ? 36'(st9_side_reg.focus_y) - 36'(st9_my_reg)
                                   : 36'(st9_side_reg.focus_y) + 36'(st9_my_reg);
        m_item_next.in_range = st9_side_reg.in_range;
        if (st9_side_reg.at_focus) begin
            m_item_next.out_x = st9_side_reg.point_x;
            m_item_next.out_y = st9_side_reg.point_y;
            m_item_next.zoom  = ZOOM_TEN;
        end else if (st9_side_reg.in_lens) begin
            m_item_next.out_x = sat32(mov_x);
            m_item_next.out_y = sat32(mov_y);
            m_item_next.zoom  = st9_zoom_reg;
        end else begin
            m_item_next.out_x = st9_side_reg.point_x;
            m_item_next.out_y = st9_side_reg.point_y;
            m_item_next.zoom  = ZOOM_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st7_side_reg <= dv_side;
            st7_k_reg    <= 62'((63'(dv_quo) + (63'(dv_quo) << 1)) >> 2)
                            + (62'(cfpd_pkg::WONE) >> 2);

            st8_side_reg <= st7_side_reg;
            st8_zoom_reg <= zsel[cfpd_pkg::ZOOM_W-1:0];
            st8_xl_reg   <= 62'(st7_side_reg.abs_x) * 62'(st7_k_reg[30:0]);
            st8_xh_reg   <= 62'(st7_side_reg.abs_x) * 62'(st7_k_reg[61:31]);
            st8_yl_reg   <= 62'(st7_side_reg.abs_y) * 62'(st7_k_reg[30:0]);
            st8_yh_reg   <= 62'(st7_side_reg.abs_y) * 62'(st7_k_reg[61:31]);

            st9_side_reg <= st8_side_reg;
            st9_zoom_reg <= st8_zoom_reg;
            st9_mx_reg   <= sum_x[63:30];
            st9_my_reg   <= sum_y[63:30];

            m_item_reg   <= m_item_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
            st5_valid_reg <= 1'b0;
            st6_valid_reg <= 1'b0;
            st7_valid_reg <= 1'b0;
            st8_valid_reg <= 1'b0;
            st9_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else if (en) begin
            st1_valid_reg <= in_valid;
            st2_valid_reg <= st1_valid_reg;
            st3_valid_reg <= st2_valid_reg;
            st4_valid_reg <= st3_valid_reg;
            st5_valid_reg <= st4_valid_reg;
            st6_valid_reg <= ex_valid;
            st7_valid_reg <= dv_valid;
            st8_valid_reg <= st7_valid_reg;
            st9_valid_reg <= st8_valid_reg;
            m_valid_reg   <= st9_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
